[src/rotation_matrix_composer_unit_defines.svh]
// Assertion helpers used by the RTL.
`ifndef ROTATION_MATRIX_COMPOSER_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_COMPOSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmc check failed");

// Next-cycle implication, checked out of reset.
`define RMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmc check failed");

`endif

[src/rmc_pkg.sv]
package rmc_pkg;

  localparam int ENTRY_W      = 16;
  localparam int FRAC_W       = ENTRY_W - 2;
  localparam int SINE_D       = 256;
  localparam int SINE_SH      = $clog2(2 * SINE_D);
  localparam int IDX_W        = $clog2(SINE_D + 1);
  localparam int ANGLE_W      = 17;
  localparam int AXIS_W       = 2;
  localparam int FULL_TURN    = 2 * 180 * 128;
  localparam int QUARTER      = FULL_TURN / 4;
  localparam int HALF_QUARTER = QUARTER / 2;
  localparam int REM_W        = $clog2(QUARTER);
  localparam int PR_W         = REM_W + 1;
  localparam int NUM_W        = $clog2(QUARTER * (SINE_D + 1));
  localparam int ACC_W        = 2 * ENTRY_W + 2;
  localparam int IN_DATA_W    = ((AXIS_W + ANGLE_W + 9 * ENTRY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((9 * ENTRY_W + 7) / 8) * 8;
  localparam int DIV_CNT_W    = $clog2(IDX_W + 1);

  // Rotation axis codes.
  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef entry_t sine_tab_t [SINE_D+1];

  // Control that goes with each operand pair into the multiply-accumulate unit.
  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctl_t;

  localparam entry_t ONE = entry_t'(1) <<< FRAC_W;

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series of the sine with truncating steps.
  function automatic longint sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 30;
      term = udiv64(term, 64'((2 * k) * (2 * k + 1)));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  // Quarter-wave table, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint          s;
    int              sh;
    sh = 30 - FRAC_W;
    for (int i = 0; i <= SINE_D; i++) begin
      x = (PI_Q30 * 64'(i) + 64'(SINE_D)) >> SINE_SH;
      s = sine_q30(x);
      if (sh > 0) begin
        s = (s + (longint'(1) << (sh - 1))) >>> sh;
      end
      tab[i] = entry_t'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[src/rmc_idx_div.sv]
// Restoring divider, one quotient bit per cycle: table index from the angle remainder.
module rmc_idx_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rmc_pkg::NUM_W-1:0]   num,
  output logic                        done,
  output logic [rmc_pkg::IDX_W-1:0]   quot
);

  logic [rmc_pkg::PR_W-1:0]      pr_r, pr_nxt;
  logic [rmc_pkg::IDX_W-1:0]     low_r, q_r;
  logic [rmc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [rmc_pkg::PR_W-1:0]      trial;
  logic                          fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial  = {pr_r[rmc_pkg::PR_W-2:0], low_r[rmc_pkg::IDX_W-1]};
    fits   = trial >= rmc_pkg::PR_W'(rmc_pkg::QUARTER);
    pr_nxt = fits ? trial - rmc_pkg::PR_W'(rmc_pkg::QUARTER) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rmc_pkg::DIV_CNT_W'(rmc_pkg::IDX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      pr_r  <= rmc_pkg::PR_W'(num >> rmc_pkg::IDX_W);
      low_r <= num[rmc_pkg::IDX_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      pr_r  <= pr_nxt;
      low_r <= {low_r[rmc_pkg::IDX_W-2:0], 1'b0};
      q_r   <= {q_r[rmc_pkg::IDX_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[src/rmc_mac.sv]
// Shared multiplier and accumulator; rounds and saturates each finished dot product.
module rmc_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  rmc_pkg::mac_ctl_t   ctl,
  input  rmc_pkg::entry_t     a,
  input  rmc_pkg::entry_t     b,
  output logic                res_valid,
  output rmc_pkg::entry_t     res,
  output logic                res_sat
);

  logic signed [2*rmc_pkg::ENTRY_W-1:0] prod_r;
  logic signed [rmc_pkg::ACC_W-1:0]     acc_r;
  logic                                 v1_r, first1_r, last1_r, out_v_r;
  logic signed [rmc_pkg::ACC_W:0]       rnd;
  logic signed [rmc_pkg::ACC_W:0]       maxv, minv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v1_r    <= ctl.issue;
      out_v_r <= v1_r && last1_r;
    end
  end

  // Product stage, then accumulate.
  always_ff @(posedge clk) begin
    prod_r   <= a * b;
    first1_r <= ctl.first;
    last1_r  <= ctl.last;
    if (v1_r) begin
      acc_r <= first1_r ? rmc_pkg::ACC_W'(prod_r) : acc_r + rmc_pkg::ACC_W'(prod_r);
    end
  end

  // Round half up at the fraction point, then clip.
  always_comb begin
    maxv = (rmc_pkg::ACC_W+1)'(rmc_pkg::entry_t'({1'b0, {(rmc_pkg::ENTRY_W-1){1'b1}}}));
    minv = (rmc_pkg::ACC_W+1)'(rmc_pkg::entry_t'({1'b1, {(rmc_pkg::ENTRY_W-1){1'b0}}}));
    rnd  = ((rmc_pkg::ACC_W+1)'(acc_r) + ((rmc_pkg::ACC_W+1)'(1) <<< (rmc_pkg::FRAC_W - 1)))
           >>> rmc_pkg::FRAC_W;
    res_sat = 1'b0;
    priority if (rnd > maxv) begin
      res     = maxv[rmc_pkg::ENTRY_W-1:0];
      res_sat = 1'b1;
    end else if (rnd < minv) begin
      res     = minv[rmc_pkg::ENTRY_W-1:0];
      res_sat = 1'b1;
    end else begin
      res = rnd[rmc_pkg::ENTRY_W-1:0];
    end
  end

  assign res_valid = out_v_r;

endmodule

[src/rotation_matrix_composer_unit.sv]
// Rotation matrix composer.
// Input channel in_*: one request per command. in_tuser[0] is the command
// (0 load an axis rotation, 1 multiply the held matrix by a supplied one).
// Output channel out_*: one result per request with all nine held entries
// and a saturation flag in out_tuser[0].
// A rotation passes through angle reduction, a 9-step serial index
// division and table lookup before out_tvalid.
// A multiply sends 27 products through one shared multiplier, one per
// cycle, followed by the multiply and accumulate stages.
// A new request is taken once the previous one has reached the output
// register, even while that result still waits for out_tready.
// A stalled receiver holds the output register; a finished request then
// waits in its last state until the register frees up.
// Reset is synchronous and active low; it loads the identity matrix and
// empties the output register.
module rotation_matrix_composer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // axis, angle, m_00..m_22, zero pad
  input  logic [rmc_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // r_00..r_22
  output logic [rmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // saturated
  output logic [0:0]                      out_tuser
);

`include "rotation_matrix_composer_unit_defines.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]                        state_r;
  logic                              cmd_r;
  logic [rmc_pkg::AXIS_W-1:0]        axis_r;
  logic signed [rmc_pkg::ANGLE_W-1:0] angle_r;
  rmc_pkg::entry_t                   m_r   [3][3];
  rmc_pkg::entry_t                   h_r   [3][3];
  rmc_pkg::entry_t                   res_r [3][3];
  rmc_pkg::entry_t                   rot_m [3][3];
  logic [1:0]                        quad_r;
  logic [rmc_pkg::NUM_W-1:0]         num_r;
  logic                              div_start_r;
  logic                              div_done;
  logic [rmc_pkg::IDX_W-1:0]         idx;
  logic [1:0]                        ir_r, ic_r, ik_r, wr_r, wc_r;
  logic                              issuing_r;
  logic                              sat_r;
  logic                              out_v_r;
  logic [rmc_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic                              out_sat_r;
  rmc_pkg::mac_ctl_t                 mac_ctl;
  logic                              mac_v;
  rmc_pkg::entry_t                   mac_res;
  logic                              mac_sat;
  logic                              accept;
  logic signed [rmc_pkg::ANGLE_W+1:0] a_ext, a_mod;
  logic [rmc_pkg::REM_W+1:0]         a_u;
  logic [rmc_pkg::REM_W-1:0]         rem;
  logic [1:0]                        quad;
  rmc_pkg::entry_t                   s0, c0, sn, cs;
  logic                              out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_v_r || out_tready;

  // Reduce the angle to one turn, then split into quadrant and remainder.
  always_comb begin
    a_ext = (rmc_pkg::ANGLE_W+2)'(angle_r);
    priority if (a_ext < -(rmc_pkg::ANGLE_W+2)'(rmc_pkg::FULL_TURN)) begin
      a_mod = a_ext + (rmc_pkg::ANGLE_W+2)'(2 * rmc_pkg::FULL_TURN);
    end else if (a_ext < 0) begin
      a_mod = a_ext + (rmc_pkg::ANGLE_W+2)'(rmc_pkg::FULL_TURN);
    end else if (a_ext >= (rmc_pkg::ANGLE_W+2)'(rmc_pkg::FULL_TURN)) begin
      a_mod = a_ext - (rmc_pkg::ANGLE_W+2)'(rmc_pkg::FULL_TURN);
    end else begin
      a_mod = a_ext;
    end
    a_u = a_mod[rmc_pkg::REM_W+1:0];
    priority if (a_u >= (rmc_pkg::REM_W+2)'(3 * rmc_pkg::QUARTER)) begin
      quad = 2'd3;
      rem  = rmc_pkg::REM_W'(a_u - (rmc_pkg::REM_W+2)'(3 * rmc_pkg::QUARTER));
    end else if (a_u >= (rmc_pkg::REM_W+2)'(2 * rmc_pkg::QUARTER)) begin
      quad = 2'd2;
      rem  = rmc_pkg::REM_W'(a_u - (rmc_pkg::REM_W+2)'(2 * rmc_pkg::QUARTER));
    end else if (a_u >= (rmc_pkg::REM_W+2)'(rmc_pkg::QUARTER)) begin
      quad = 2'd1;
      rem  = rmc_pkg::REM_W'(a_u - (rmc_pkg::REM_W+2)'(rmc_pkg::QUARTER));
    end else begin
      quad = 2'd0;
      rem  = rmc_pkg::REM_W'(a_u);
    end
  end

  // Table lookup and quadrant signs.
  always_comb begin
    s0 = rmc_pkg::SINE_TAB[idx];
    c0 = rmc_pkg::SINE_TAB[rmc_pkg::IDX_W'(rmc_pkg::SINE_D) - idx];
    unique case (quad_r)
      2'd0: begin
        sn = s0;
        cs = c0;
      end
      2'd1: begin
        sn = c0;
        cs = -s0;
      end
      2'd2: begin
        sn = -s0;
        cs = -c0;
      end
      default: begin
        sn = -c0;
        cs = s0;
      end
    endcase
  end

  // Elementary rotation about the requested axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_m[i][j] = '0;
      end
    end
    unique case (axis_r)
      rmc_pkg::AXIS_X: begin
        rot_m[0][0] = rmc_pkg::ONE;
        rot_m[1][1] = cs;
        rot_m[1][2] = -sn;
        rot_m[2][1] = sn;
        rot_m[2][2] = cs;
      end
      rmc_pkg::AXIS_Y: begin
        rot_m[0][0] = cs;
        rot_m[0][2] = sn;
        rot_m[1][1] = rmc_pkg::ONE;
        rot_m[2][0] = -sn;
        rot_m[2][2] = cs;
      end
      default: begin
        rot_m[0][0] = cs;
        rot_m[0][1] = -sn;
        rot_m[1][0] = sn;
        rot_m[1][1] = cs;
        rot_m[2][2] = rmc_pkg::ONE;
      end
    endcase
  end

  assign mac_ctl.issue = issuing_r;
  assign mac_ctl.first = (ik_r == 2'd0);
  assign mac_ctl.last  = (ik_r == 2'd2);

  rmc_idx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_r),
    .done  (div_done),
    .quot  (idx)
  );

  rmc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .a         (h_r[ir_r][ik_r]),
    .b         (m_r[ik_r][ic_r]),
    .res_valid (mac_v),
    .res       (mac_res),
    .res_sat   (mac_sat)
  );

  // Sequencer and held matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      issuing_r   <= 1'b0;
      out_v_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          h_r[i][j] <= (i == j) ? rmc_pkg::ONE : '0;
        end
      end
    end else begin
      div_start_r <= 1'b0;
      // The finish state reloads the register itself when it frees up.
      if (out_v_r && out_tready && state_r != ST_FIN) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            sat_r <= 1'b0;
            if (in_tuser[0]) begin
              state_r   <= ST_MUL;
              issuing_r <= 1'b1;
              ir_r      <= '0;
              ic_r      <= '0;
              ik_r      <= '0;
              wr_r      <= '0;
              wc_r      <= '0;
            end else begin
              state_r <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          quad_r      <= quad;
          num_r       <= rmc_pkg::NUM_W'(rem) * rmc_pkg::NUM_W'(rmc_pkg::SINE_D)
                         + rmc_pkg::NUM_W'(rmc_pkg::HALF_QUARTER);
          div_start_r <= 1'b1;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
            if (axis_r != rmc_pkg::AXIS_NONE) begin
              for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                  h_r[i][j] <= rot_m[i][j];
                end
              end
            end
          end
        end
        ST_MUL: begin
          // Walk k fastest, then column, then row.
          if (issuing_r) begin
            if (ik_r == 2'd2) begin
              ik_r <= '0;
              if (ic_r == 2'd2) begin
                ic_r <= '0;
                if (ir_r == 2'd2) begin
                  issuing_r <= 1'b0;
                end else begin
                  ir_r <= ir_r + 1'b1;
                end
              end else begin
                ic_r <= ic_r + 1'b1;
              end
            end else begin
              ik_r <= ik_r + 1'b1;
            end
          end
          // Collect finished entries; the last one commits the product.
          if (mac_v) begin
            sat_r <= sat_r | mac_sat;
            res_r[wr_r][wc_r] <= mac_res;
            if (wc_r == 2'd2) begin
              wc_r <= '0;
              wr_r <= wr_r + 1'b1;
            end else begin
              wc_r <= wc_r + 1'b1;
            end
            if (wr_r == 2'd2 && wc_r == 2'd2) begin
              for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                  h_r[i][j] <= (i == 2 && j == 2) ? mac_res : res_r[i][j];
                end
              end
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_v_r   <= 1'b1;
            out_sat_r <= sat_r;
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                out_data_r[(i * 3 + j) * rmc_pkg::ENTRY_W +: rmc_pkg::ENTRY_W] <= h_r[i][j];
              end
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tuser[0];
      axis_r  <= in_tdata[rmc_pkg::AXIS_W-1:0];
      angle_r <= in_tdata[rmc_pkg::AXIS_W +: rmc_pkg::ANGLE_W];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m_r[i][j] <= in_tdata[rmc_pkg::AXIS_W + rmc_pkg::ANGLE_W
                                + (i * 3 + j) * rmc_pkg::ENTRY_W +: rmc_pkg::ENTRY_W];
        end
      end
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  `RMC_ASSERT_NEXT(a_accept_blocks, accept, !in_tready)
  `RMC_ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV && !cmd_r)
  `RMC_ASSERT_NOW(a_mac_only_in_mul, mac_v, state_r == ST_MUL && cmd_r)
  `RMC_ASSERT_NEXT(a_fin_loads_out, state_r == ST_FIN && out_free, out_tvalid)

endmodule
